/* hw/rtl/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types and constants for the CIGAR identity scanner.
// ----------------------------------------------------------------------------
package cis_pkg;

  // Default counter width; the top level hands it down as COUNT_WIDTH.
  localparam int CIS_COUNT_WIDTH = 32;

  // Fixed-point format of the identities: 1.0 is 2**FRACTION_BITS.
  localparam int FRACTION_BITS = 16;
  localparam int IDENT_W       = FRACTION_BITS + 1;
  localparam logic [IDENT_W-1:0] IDENT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 32;
  localparam int MATCH_OUT_W = 32;
  localparam int THRESH_W    = 16;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd10;

  // Run lengths are decimal.
  localparam int DECIMAL_BASE = 10;

  // Three identities are worked out side by side.
  localparam int NUM_IDENT = 3;
  localparam int IDX_ALL   = 0;
  localparam int IDX_SHORT = 1;
  localparam int IDX_MIN   = 2;

  // Bit-serial divide: one quotient bit per cycle.
  localparam int STEP_CNT_W = $clog2(FRACTION_BITS);

  // Job queue between the scanner and the divider; power of two.
  localparam int QUEUE_DEPTH = 2;

  // CIGAR characters
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;  // 'M'
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;  // 'X'
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;  // 'I'
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;  // 'D'

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_MATCH,
    OP_MISMATCH,
    OP_GAP,
    OP_SKIP
  } cis_op_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
    logic [LEN_W-1:0]  first_length;
    logic [LEN_W-1:0]  second_length;
  } cis_in_t;

  typedef struct packed {
    logic [IDENT_W-1:0]     identity_all;
    logic [IDENT_W-1:0]     identity_short_gaps;
    logic [IDENT_W-1:0]     identity_shorter;
    logic [MATCH_OUT_W-1:0] match_count;
  } cis_out_t;

endpackage

/* hw/rtl/cis_front.sv */
// ----------------------------------------------------------------------------
// cis_front
// Scans CIGAR bytes, keeps the run length and saturating totals, and pushes
// one job per string into the divider queue on the final byte.
// ----------------------------------------------------------------------------
module cis_front import cis_pkg::*; #(
  parameter int  COUNT_WIDTH = CIS_COUNT_WIDTH,
  localparam int JOB_W       = 3 * COUNT_WIDTH + LEN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cis_in_t             in_data,
  input  logic                cfg_wr_en,
  input  logic [THRESH_W-1:0] cfg_wr_data,
  output logic                job_push,
  output logic [JOB_W-1:0]    job_data,
  input  logic                job_full
);

  localparam int RUN_EXT_W = COUNT_WIDTH + 4;

  logic [THRESH_W-1:0]    thresh_r;
  logic [COUNT_WIDTH-1:0] run_r, match_r, col_r, long_r;
  logic [COUNT_WIDTH-1:0] run_nxt, match_nxt, col_nxt, long_nxt;

  cis_op_t                op;
  logic                   accept;
  logic [CHAR_W-1:0]      char_off;
  logic [RUN_EXT_W-1:0]   run_dec;
  logic [COUNT_WIDTH-1:0] run_sat;
  logic                   is_long;
  logic [LEN_W-1:0]       shorter;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(
    input logic [COUNT_WIDTH-1:0] a,
    input logic [COUNT_WIDTH-1:0] b
  );
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    op = OP_SKIP;
    unique case (in_data.char_code) inside
      [CH_ZERO:CH_NINE]: op = OP_DIGIT;
      CH_M, CH_EQ:       op = OP_MATCH;
      CH_X:              op = OP_MISMATCH;
      CH_I, CH_D:        op = OP_GAP;
      default:           op = OP_SKIP;
    endcase
  end

  // run * 10 + digit, clamp on overflow
  assign char_off = in_data.char_code - CH_ZERO;
  assign run_dec  = (RUN_EXT_W'(run_r) * RUN_EXT_W'(DECIMAL_BASE))
                    + RUN_EXT_W'(char_off[3:0]);
  assign run_sat  = (run_dec[RUN_EXT_W-1:COUNT_WIDTH] != '0) ? '1
                                                             : run_dec[COUNT_WIDTH-1:0];
  assign is_long  = run_r >= COUNT_WIDTH'(thresh_r);

  assign shorter  = (in_data.first_length < in_data.second_length) ?
                    in_data.first_length : in_data.second_length;

  always_comb begin
    run_nxt   = run_r;
    match_nxt = match_r;
    col_nxt   = col_r;
    long_nxt  = long_r;
    if (accept) begin
      case (op)
        OP_DIGIT: run_nxt = run_sat;
        OP_MATCH: begin
          match_nxt = sat_add(match_r, run_r);
          col_nxt   = sat_add(col_r, run_r);
          run_nxt   = '0;
        end
        OP_MISMATCH: begin
          col_nxt = sat_add(col_r, run_r);
          run_nxt = '0;
        end
        OP_GAP: begin
          col_nxt = sat_add(col_r, run_r);
          if (is_long) begin
            long_nxt = sat_add(long_r, run_r);
          end
          run_nxt = '0;
        end
        default: run_nxt = '0;
      endcase
    end
  end

  assign job_push = accept && in_data.end_of_string;
  assign job_data = {match_nxt, col_nxt, long_nxt, shorter};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      run_r    <= '0;
      match_r  <= '0;
      col_r    <= '0;
      long_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      // drop trailing digits and start the next string clean
      if (job_push) begin
        run_r   <= '0;
        match_r <= '0;
        col_r   <= '0;
        long_r  <= '0;
      end else begin
        run_r   <= run_nxt;
        match_r <= match_nxt;
        col_r   <= col_nxt;
        long_r  <= long_nxt;
      end
    end
  end

endmodule

/* hw/rtl/cis_queue.sv */
// ----------------------------------------------------------------------------
// cis_queue
// Small FIFO of finished-string jobs between the scanner and the divider.
// ----------------------------------------------------------------------------
module cis_queue import cis_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW:0]      wr_ptr_r, rd_ptr_r;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                    (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign pop_data = entry_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/cis_back.sv */
// ----------------------------------------------------------------------------
// cis_back
// Takes one job at a time and runs three restoring fraction dividers side by
// side, one quotient bit per cycle, then parks the word in the output register.
// ----------------------------------------------------------------------------
module cis_back import cis_pkg::*; #(
  parameter int  COUNT_WIDTH = CIS_COUNT_WIDTH,
  localparam int JOB_W       = 3 * COUNT_WIDTH + LEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_empty,
  output logic             job_pop,
  input  logic [JOB_W-1:0] job_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cis_out_t         out_data
);

  localparam int DEN_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0]   match_r, col_r, long_r;
  logic [LEN_W-1:0]         short_r;
  logic [DEN_W-1:0]         den_r  [NUM_IDENT];
  logic [DEN_W-1:0]         rem_r  [NUM_IDENT];
  logic [FRACTION_BITS-1:0] quo_r  [NUM_IDENT];
  logic                     zero_r [NUM_IDENT];
  logic                     sat_r  [NUM_IDENT];
  logic [STEP_CNT_W-1:0]    cnt_r;
  logic                     out_valid_r;
  cis_out_t                 out_data_r;

  logic [DEN_W-1:0] num_ext;
  logic [DEN_W:0]   shifted [NUM_IDENT];
  logic [DEN_W:0]   diff    [NUM_IDENT];
  logic             ge      [NUM_IDENT];
  logic [DEN_W-1:0] rem_step[NUM_IDENT];
  logic             out_free;
  logic             match_big;

  function automatic logic [IDENT_W-1:0] ident_of(
    input logic                     is_zero,
    input logic                     is_sat,
    input logic [FRACTION_BITS-1:0] q
  );
    if (is_zero) begin
      return '0;
    end else if (is_sat) begin
      return IDENT_ONE;
    end
    return {1'b0, q};
  endfunction

  assign num_ext   = DEN_W'(match_r);
  assign match_big = (num_ext >> MATCH_OUT_W) != '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign job_pop   = (state_r == S_IDLE) && !job_empty;

  always_comb begin
    for (int i = 0; i < NUM_IDENT; i++) begin
      shifted[i]  = {rem_r[i], 1'b0};
      diff[i]     = shifted[i] - {1'b0, den_r[i]};
      ge[i]       = shifted[i] >= {1'b0, den_r[i]};
      rem_step[i] = ge[i] ? diff[i][DEN_W-1:0] : shifted[i][DEN_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!job_empty) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == STEP_CNT_W'(FRACTION_BITS - 1)) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (job_pop) begin
          {match_r, col_r, long_r, short_r} <= job_data;
        end
      end
      S_LOAD: begin
        den_r[IDX_ALL]   <= DEN_W'(col_r);
        den_r[IDX_SHORT] <= (long_r <= col_r) ? DEN_W'(col_r - long_r) : '0;
        den_r[IDX_MIN]   <= DEN_W'(short_r);
      end
      S_CHECK: begin
        for (int i = 0; i < NUM_IDENT; i++) begin
          zero_r[i] <= (den_r[i] == '0);
          sat_r[i]  <= (num_ext >= den_r[i]);
          rem_r[i]  <= num_ext;
          quo_r[i]  <= '0;
        end
        cnt_r <= '0;
      end
      S_DIV: begin
        for (int i = 0; i < NUM_IDENT; i++) begin
          rem_r[i] <= rem_step[i];
          quo_r[i] <= {quo_r[i][FRACTION_BITS-2:0], ge[i]};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_data_r.identity_all <=
            ident_of(zero_r[IDX_ALL], sat_r[IDX_ALL], quo_r[IDX_ALL]);
          out_data_r.identity_short_gaps <=
            ident_of(zero_r[IDX_SHORT], sat_r[IDX_SHORT], quo_r[IDX_SHORT]);
          out_data_r.identity_shorter <=
            ident_of(zero_r[IDX_MIN], sat_r[IDX_MIN], quo_r[IDX_MIN]);
          out_data_r.match_count <= match_big ? '1 : num_ext[MATCH_OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/cigar_identity_scanner.sv */
// Throughput: one byte per cycle while in_stall is low; the divider works on one string
//   at a time with its one-bit-per-cycle loop; a two-deep job queue absorbs
//   short strings before the input stalls.
// Reset: synchronous, active low; clears totals, queue and output valid, threshold 10.
// ----------------------------------------------------------------------------
// cigar_identity_scanner
// Top level: byte scanner, job queue and fraction divider.
// ----------------------------------------------------------------------------
module cigar_identity_scanner import cis_pkg::*; #(
  parameter int COUNT_WIDTH = CIS_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cis_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cis_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [THRESH_W-1:0] cfg_wr_data
);

  localparam int JOB_W = 3 * COUNT_WIDTH + LEN_W;

  logic             job_push, job_pop, job_full, job_empty;
  logic [JOB_W-1:0] job_in, job_out;

  cis_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job_push    (job_push),
    .job_data    (job_in),
    .job_full    (job_full)
  );

  cis_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .full      (job_full),
    .empty     (job_empty)
  );

  cis_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_data  (job_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/cis_checker.sv */
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks on the result channel of the identity scanner.
// ----------------------------------------------------------------------------
module cis_checker import cis_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input cis_out_t out_data
);

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled word does not change
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // no identity goes above 1.0
  a_ident_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.identity_all <= IDENT_ONE &&
                  out_data.identity_short_gaps <= IDENT_ONE &&
                  out_data.identity_shorter <= IDENT_ONE)
    else $error("identity above 1.0");

  // no matches means every identity is zero
  a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_count == '0 |->
      out_data.identity_all == '0 && out_data.identity_short_gaps == '0 &&
      out_data.identity_shorter == '0)
    else $error("nonzero identity with zero matches");

endmodule

bind cigar_identity_scanner cis_checker u_cis_checker (.*);
